// ----- hdl/adfp_pkg.sv -----
// ----------------------------------------------------------------------------
// ASCII decimal to fixed-point package
// Shared constants and the word types that pass between the stages.
// ----------------------------------------------------------------------------
package adfp_pkg;

   localparam int FIELD_LEN = 10;
   localparam int FRAC_BITS = 15;

   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam int         POS_W   = 7;
   localparam logic [6:0] POS_MAX = 7'd127;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       start_req;
   } item_type;

   typedef struct packed {
      logic               emit;
      logic signed [31:0] value;
      logic               overflow;
   } result_type;

endpackage

// ----- hdl/adfp_in_reg.sv -----
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted byte until the parse stage takes it.
// ----------------------------------------------------------------------------
module adfp_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_byte_in,
   input  logic                req_start_req,
   input  logic                take,
   output logic                item_valid,
   output adfp_pkg::item_type  item
);

   logic               valid_ff;
   logic               valid_in;
   adfp_pkg::item_type item_ff;
   logic               accept;

   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.byte_in   <= req_byte_in;
         item_ff.start_req <= req_start_req;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- hdl/adfp_parse.sv -----
// ----------------------------------------------------------------------------
// Parse stage
// Holds the parse state and updates it from one byte per cycle while fire is high.
// ----------------------------------------------------------------------------
module adfp_parse #(
   parameter int FRAC_BITS = adfp_pkg::FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [5:0]           csr_skip_count,
   input  logic                 fire,
   input  adfp_pkg::item_type   item,
   output adfp_pkg::result_type result
);

   localparam int SUM_W = 38;
   localparam logic [FRAC_BITS-1:0] Tenth = FRAC_BITS'((2 ** FRAC_BITS) / 10);

   logic [5:0]            skip_ff;
   logic [6:0]            pos_ff;
   logic [6:0]            pos_in;
   logic signed [31:0]    acc_ff;
   logic signed [31:0]    acc_in;
   logic [FRAC_BITS-1:0]  weight_ff;
   logic [FRAC_BITS-1:0]  weight_in;
   logic                  dot_ff;
   logic                  dot_in;
   logic                  minus_ff;
   logic                  minus_in;
   logic                  ovf_ff;
   logic                  ovf_in;

   logic [6:0]             pos_cur;
   logic [6:0]             last;
   logic                   in_window;
   logic [3:0]             digit;
   logic signed [SUM_W-1:0] acc_w;
   logic signed [SUM_W-1:0] int_sum;
   logic signed [SUM_W-1:0] frac_sum;
   logic signed [SUM_W-1:0] sum;
   logic [FRAC_BITS+3:0]   dw_prod;
   logic [2*FRAC_BITS-1:0] w_prod;
   logic                   neg_ovf;

   always_comb begin
      pos_cur   = item.start_req ? '0 : pos_ff;
      acc_in    = item.start_req ? '0 : acc_ff;
      weight_in = item.start_req ? Tenth : weight_ff;
      dot_in    = item.start_req ? 1'b0 : dot_ff;
      minus_in  = item.start_req ? 1'b0 : minus_ff;
      ovf_in    = item.start_req ? 1'b0 : ovf_ff;

      pos_in    = (pos_cur < adfp_pkg::POS_MAX) ? pos_cur + 7'd1 : pos_cur;
      last      = {1'b0, skip_ff} + 7'(adfp_pkg::FIELD_LEN - 1);
      in_window = (pos_cur >= {1'b0, skip_ff}) && (pos_cur <= last);

      digit    = 4'(item.byte_in - adfp_pkg::CH_ZERO);
      acc_w    = SUM_W'(acc_in);
      int_sum  = (acc_w <<< 3) + (acc_w <<< 1) + (SUM_W'(digit) << FRAC_BITS);
      dw_prod  = (FRAC_BITS + 4)'(digit) * (FRAC_BITS + 4)'(weight_in);
      frac_sum = acc_w + SUM_W'(dw_prod);
      w_prod   = (2 * FRAC_BITS)'(weight_in) * (2 * FRAC_BITS)'(Tenth);
      sum      = dot_in ? frac_sum : int_sum;

      if (in_window) begin
         if (item.byte_in == adfp_pkg::CH_MINUS) begin
            minus_in = 1'b1;
         end else if (item.byte_in == adfp_pkg::CH_DOT) begin
            dot_in = 1'b1;
         end else if (item.byte_in inside {[adfp_pkg::CH_ZERO:adfp_pkg::CH_NINE]}) begin
            acc_in = sum[31:0];
            if (sum[SUM_W-1:31] != {(SUM_W - 31){sum[31]}}) begin
               ovf_in = 1'b1;
            end
            if (dot_in) begin
               weight_in = w_prod[2*FRAC_BITS-1:FRAC_BITS];
            end
         end
      end

      result.emit = in_window && (pos_cur == last);
      neg_ovf     = minus_in && (acc_in == 32'sh8000_0000);
      if (result.emit && neg_ovf) begin
         ovf_in = 1'b1;
      end
      result.value    = minus_in ? -acc_in : acc_in;
      result.overflow = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff   <= '0;
         pos_ff    <= '0;
         acc_ff    <= '0;
         weight_ff <= Tenth;
         dot_ff    <= 1'b0;
         minus_ff  <= 1'b0;
         ovf_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            skip_ff <= csr_skip_count;
         end
         if (fire) begin
            pos_ff    <= pos_in;
            acc_ff    <= acc_in;
            weight_ff <= weight_in;
            dot_ff    <= dot_in;
            minus_ff  <= minus_in;
            ovf_ff    <= ovf_in;
         end
      end
   end

   // A start byte always leaves the position at one.
   a_start_pos: assert property (@(posedge clock) disable iff (reset)
      fire && item.start_req |=> pos_ff == 7'd1)
      else $error("position after start byte is not one");

   // The overflow flag stays set until the next start byte.
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      fire && !item.start_req && ovf_ff |=> ovf_ff)
      else $error("overflow flag cleared without start");

   // The weight only moves once a dot has been seen.
   a_weight_dot: assert property (@(posedge clock) disable iff (reset)
      !dot_ff |-> weight_ff == Tenth)
      else $error("fraction weight changed before dot");

   // The weight never grows above its start value.
   a_weight_max: assert property (@(posedge clock) disable iff (reset)
      weight_ff <= Tenth)
      else $error("fraction weight above one tenth");

endmodule

// ----- hdl/adfp_out_reg.sv -----
// ----------------------------------------------------------------------------
// Result register
// Holds one finished result word until the receiver takes it.
// ----------------------------------------------------------------------------
module adfp_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  adfp_pkg::result_type  result,
   output logic                  out_free,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [31:0]    rsp_value,
   output logic                  rsp_overflow
);

   logic               valid_ff;
   logic               valid_in;
   logic signed [31:0] value_ff;
   logic               ovf_ff;
   logic               load;

   assign out_free = !valid_ff || !rsp_stall;
   assign load     = fire && result.emit;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= result.value;
         ovf_ff   <= result.overflow;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_value    = value_ff;
   assign rsp_overflow = ovf_ff;

endmodule

// ----- hdl/ascii_decimal_to_fixed_point.sv -----
// ----------------------------------------------------------------------------
// ASCII decimal to fixed-point converter
// Parses a window of command buffer bytes into a signed fixed-point word.
//
//   Channel  Direction  Handshake            Word
//   req      in         req_valid/req_stall  req_byte_in, req_start_req
//   rsp      out        rsp_valid/rsp_stall  rsp_value, rsp_overflow
//   csr      in         csr_valid/csr_ready  csr_skip_count
//
// One byte is taken every cycle while the result register is free.
// The rate is set by the single parse stage, updating its state per byte taken.
// Reset is synchronous and clears the parse state and skip_count.
// A stalled result word holds the parse stage, which in turn stalls req.
// ----------------------------------------------------------------------------
module ascii_decimal_to_fixed_point #(
   parameter int FRAC_BITS = adfp_pkg::FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_byte_in,
   input  logic               req_start_req,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic               rsp_overflow,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [5:0]         csr_skip_count
);

   adfp_pkg::item_type   item;
   adfp_pkg::result_type result;
   logic                 item_valid;
   logic                 out_free;
   logic                 fire;

   assign csr_ready = 1'b1;
   assign fire      = item_valid && out_free;

   adfp_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_byte_in   (req_byte_in),
      .req_start_req (req_start_req),
      .take          (fire),
      .item_valid    (item_valid),
      .item          (item)
   );

   adfp_parse #(
      .FRAC_BITS (FRAC_BITS)
   ) u_parse (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_valid && csr_ready),
      .csr_skip_count (csr_skip_count),
      .fire           (fire),
      .item           (item),
      .result         (result)
   );

   adfp_out_reg u_out_reg (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .result       (result),
      .out_free     (out_free),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_value    (rsp_value),
      .rsp_overflow (rsp_overflow)
   );

endmodule
